/* rtl/core/csvtok_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types and character constants for the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } token_kind_t;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic cr_pending;
        logic field_empty;
        logic record_started;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        in_quotes:      1'b0,
        quote_pending:  1'b0,
        cr_pending:     1'b0,
        field_empty:    1'b1,
        record_started: 1'b0
    };

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic [7:0]  value;
    } token_t;

endpackage
`default_nettype wire

/* rtl/core/csvtok_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_parser
// Quoting and record state with the per-character token decision.
// ----------------------------------------------------------------------------
module csvtok_parser
    import csvtok_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_stream,
    output token_t          tok
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         quotes_eff;
    logic         is_quote;
    logic         is_comma;
    logic         is_lf;
    logic         is_cr;

    assign is_quote = (in_byte == CH_QUOTE);
    assign is_comma = (in_byte == CH_COMMA);
    assign is_lf    = (in_byte == CH_LF);
    assign is_cr    = (in_byte == CH_CR);

    always_comb
    begin
        state_next = state_reg;
        tok        = '{valid: 1'b0, kind: KIND_VALUE, value: 8'h00};
        quotes_eff = state_reg.in_quotes;
        if (end_of_stream)
        begin
            state_next = PARSE_STATE_RESET;
            if (state_reg.record_started)
            begin
                tok = '{valid: 1'b1, kind: KIND_RECORD, value: 8'h00};
            end
        end
        else if (state_reg.cr_pending && is_lf)
        begin
            // lf of a crlf pair
            state_next.cr_pending = 1'b0;
        end
        else if (state_reg.quote_pending && is_quote)
        begin
            // doubled quote inside quotes
            state_next.cr_pending    = 1'b0;
            state_next.quote_pending = 1'b0;
            state_next.field_empty   = 1'b0;
            tok = '{valid: 1'b1, kind: KIND_VALUE, value: CH_QUOTE};
        end
        else
        begin
            state_next.cr_pending     = 1'b0;
            state_next.quote_pending  = 1'b0;
            state_next.record_started = 1'b1;
            if (state_reg.quote_pending)
            begin
                quotes_eff = 1'b0;
            end
            state_next.in_quotes = quotes_eff;
            if (quotes_eff && is_quote)
            begin
                state_next.quote_pending = 1'b1;
            end
            else if (is_quote && state_reg.field_empty)
            begin
                state_next.in_quotes = 1'b1;
            end
            else if (!quotes_eff && is_comma)
            begin
                state_next.field_empty = 1'b1;
                tok = '{valid: 1'b1, kind: KIND_FIELD, value: 8'h00};
            end
            else if (!quotes_eff && (is_lf || is_cr))
            begin
                state_next.field_empty    = 1'b1;
                state_next.record_started = 1'b0;
                state_next.cr_pending     = is_cr;
                tok = '{valid: 1'b1, kind: KIND_RECORD, value: 8'h00};
            end
            else
            begin
                state_next.field_empty = 1'b0;
                tok = '{valid: 1'b1, kind: KIND_VALUE, value: in_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_STATE_RESET;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/csv_record_tokenizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// a word accepted into the input register has its token captured in the result register when the word is consumed
// throughput: one input word per cycle, sustained while out_ready stays high
// the output register stalls the input register, which stalls in_ready, through one gate path
// words that give no token still pass through the input register
// reset (rst_n low, asynchronous) empties both registers and returns the parser to field start
// ----------------------------------------------------------------------------
// csv_record_tokenizer_top
// CSV text tokenizer: value bytes, field ends and record ends, at most one per word.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_top
    import csvtok_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_stream,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      token_kind,
    output logic [7:0]      value_byte
);

    logic        in_vld_reg;
    logic [7:0]  byte_reg;
    logic        eos_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    token_kind_t kind_reg;
    logic [7:0]  value_reg;
    logic        out_free;
    logic        consume;
    token_t      tok;

    assign out_free = !out_vld_reg || out_ready;
    assign consume  = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || out_free;

    csvtok_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (consume),
        .in_byte       (byte_reg),
        .end_of_stream (eos_reg),
        .tok           (tok)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_stream;
        end
    end

    // result register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_free)
        begin
            out_vld_next = consume && tok.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && tok.valid)
        begin
            kind_reg  <= tok.kind;
            value_reg <= tok.value;
        end
    end

    assign out_valid  = out_vld_reg;
    assign token_kind = kind_reg;
    assign value_byte = value_reg;

endmodule
`default_nettype wire

/* rtl/core/csvtok_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks on the token stream of the CSV record tokenizer.
// ----------------------------------------------------------------------------
module csvtok_checker
    import csvtok_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] token_kind,
    input wire logic [7:0] value_byte
);

    // only the three token kinds leave the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_kind == KIND_VALUE || token_kind == KIND_FIELD
                       || token_kind == KIND_RECORD))
        else $error("illegal token kind");

    // field and record ends carry a zero byte
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind != KIND_VALUE) |-> (value_byte == 8'h00))
        else $error("end token with non-zero byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(token_kind) && $stable(value_byte)))
        else $error("stalled token changed");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("token withdrawn before taken");

endmodule

bind csv_record_tokenizer_top csvtok_checker u_csvtok_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .value_byte (value_byte)
);
`default_nettype wire
